// ===== design/rmf_pkg.sv =====
// Package for the running median filter: widths, window limits, state type
// and the modular pointer helper. No dependencies.
package rmf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int REQ_W      = 6;
	localparam int MAX_WINDOW = 15;
	localparam int PTR_W      = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W      = CNT_W + 1;

	localparam int MIN_WINDOW = 3;
	localparam int WIN_CAP    = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;

	localparam logic [REQ_W-1:0] REQ_RESET = REQ_W'(5);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_WRITE = 5'b00010,
		ST_LOAD  = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_CHECK = 5'b10000
	} state_t;

	// Adds an offset below MAX_WINDOW to a slot index, wrapping around the store.
	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
			input logic [CNT_W-1:0] ofs);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(ptr) + SUM_W'(ofs);
		if (sum >= SUM_W'(MAX_WINDOW)) begin
			sum = sum - SUM_W'(MAX_WINDOW);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

// ===== design/running_median_filter_top.sv =====
// Running median filter: circular sample store and a sequencer that selects
// the median with one shared compare unit. Depends on rmf_pkg.
// Sequence: an accepted sample is written into the store; then each candidate in
// turn is loaded, compared against all held samples and checked, until the median
// is found, after at most held tries (held: sample count after insertion, up to 15).
// One item at a time: the input is not ready until the result is loaded into
// the output register, which waits while an earlier result is still stalled.
// Reset (arst_n low, asynchronous) empties the window and sets the request to 5.
module running_median_filter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [15:0] median
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);

	rmf_pkg::state_t state_q;

	logic [rmf_pkg::REQ_W-1:0]    req_q;
	logic [rmf_pkg::SAMPLE_W-1:0] store_q [rmf_pkg::MAX_WINDOW];
	logic [rmf_pkg::SAMPLE_W-1:0] sample_q;
	logic [rmf_pkg::SAMPLE_W-1:0] cand_q;
	logic [rmf_pkg::SAMPLE_W-1:0] median_q;
	logic                         out_valid_q;
	logic [rmf_pkg::CNT_W-1:0]    held_q;
	logic [rmf_pkg::PTR_W-1:0]    oldest_q;
	logic [rmf_pkg::PTR_W-1:0]    cand_ptr_q;
	logic [rmf_pkg::PTR_W-1:0]    scan_ptr_q;
	logic [rmf_pkg::CNT_W-1:0]    scan_cnt_q;
	logic [rmf_pkg::CNT_W-1:0]    lt_q;
	logic [rmf_pkg::CNT_W-1:0]    eq_q;

	logic [rmf_pkg::REQ_W-1:0]    req_odd;
	logic [rmf_pkg::REQ_W-1:0]    win_full;
	logic [rmf_pkg::CNT_W-1:0]    win;
	logic [rmf_pkg::CNT_W-1:0]    drop;
	logic [rmf_pkg::PTR_W-1:0]    rd_ptr;
	logic [rmf_pkg::SAMPLE_W-1:0] rd_data;
	logic [rmf_pkg::CNT_W-1:0]    mid;
	logic [rmf_pkg::SUM_W-1:0]    lt_eq;
	logic                         found;
	logic                         in_acc;
	logic                         res_load;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == rmf_pkg::ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = median_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		req_odd = req_q | rmf_pkg::REQ_W'(1);
		if (req_odd < rmf_pkg::REQ_W'(rmf_pkg::MIN_WINDOW)) begin
			win_full = rmf_pkg::REQ_W'(rmf_pkg::MIN_WINDOW);
		end else if (req_odd > rmf_pkg::REQ_W'(rmf_pkg::WIN_CAP)) begin
			win_full = rmf_pkg::REQ_W'(rmf_pkg::WIN_CAP);
		end else begin
			win_full = req_odd;
		end
		win  = win_full[rmf_pkg::CNT_W-1:0];
		drop = held_q - win + rmf_pkg::CNT_W'(1);
	end

	assign rd_ptr   = (state_q == rmf_pkg::ST_LOAD) ? cand_ptr_q : scan_ptr_q;
	assign rd_data  = store_q[rd_ptr];
	assign mid      = held_q >> 1;
	assign lt_eq    = rmf_pkg::SUM_W'(lt_q) + rmf_pkg::SUM_W'(eq_q);
	assign found    = (lt_q <= mid) && (rmf_pkg::SUM_W'(mid) < lt_eq);
	assign res_load = (state_q == rmf_pkg::ST_CHECK) && found && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= rmf_pkg::REQ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			req_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rmf_pkg::ST_WRITE) begin
			store_q[rmf_pkg::wrap_add(oldest_q, held_q)] <= sample_q;
		end
		if (in_acc) begin
			sample_q <= s_axis_tdata;
		end
		if (state_q == rmf_pkg::ST_LOAD) begin
			cand_q <= rd_data;
		end
		if (res_load) begin
			median_q <= cand_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			held_q      <= '0;
			oldest_q    <= '0;
			cand_ptr_q  <= '0;
			scan_ptr_q  <= '0;
			scan_cnt_q  <= '0;
			lt_q        <= '0;
			eq_q        <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				rmf_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (held_q >= win) begin
							oldest_q <= rmf_pkg::wrap_add(oldest_q, drop);
							held_q   <= win - rmf_pkg::CNT_W'(1);
						end
						state_q <= rmf_pkg::ST_WRITE;
					end
				end
				rmf_pkg::ST_WRITE: begin
					held_q     <= held_q + rmf_pkg::CNT_W'(1);
					cand_ptr_q <= oldest_q;
					state_q    <= rmf_pkg::ST_LOAD;
				end
				rmf_pkg::ST_LOAD: begin
					scan_ptr_q <= oldest_q;
					scan_cnt_q <= '0;
					lt_q       <= '0;
					eq_q       <= '0;
					state_q    <= rmf_pkg::ST_SCAN;
				end
				rmf_pkg::ST_SCAN: begin
					if (rd_data < cand_q) begin
						lt_q <= lt_q + rmf_pkg::CNT_W'(1);
					end
					if (rd_data == cand_q) begin
						eq_q <= eq_q + rmf_pkg::CNT_W'(1);
					end
					scan_ptr_q <= rmf_pkg::wrap_add(scan_ptr_q, rmf_pkg::CNT_W'(1));
					scan_cnt_q <= scan_cnt_q + rmf_pkg::CNT_W'(1);
					if (scan_cnt_q == held_q - rmf_pkg::CNT_W'(1)) begin
						state_q <= rmf_pkg::ST_CHECK;
					end
				end
				rmf_pkg::ST_CHECK: begin
					if (found) begin
						if (res_load) begin
							state_q <= rmf_pkg::ST_IDLE;
						end
					end else begin
						cand_ptr_q <= rmf_pkg::wrap_add(cand_ptr_q, rmf_pkg::CNT_W'(1));
						state_q    <= rmf_pkg::ST_LOAD;
					end
				end
				default: begin
					state_q <= rmf_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/rmf_checker.sv =====
// Port-level checker for the running median filter, bound to the top level.
// Depends only on the ports of running_median_filter_top.
module rmf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        cfg_ready
);

	// An accepted item keeps the input closed through insertion, load and first compare.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
		else $error("input reopened too early after an accepted item");

	// A waiting result stays valid and unchanged until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result dropped or changed while stalled");

	// A new result appears only when the input was closed in the previous cycle.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(m_axis_tvalid)) |-> $past(!s_axis_tready))
		else $error("result appeared without work in progress");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind running_median_filter_top rmf_checker u_rmf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_ready     (cfg_ready)
);

// ===== tb/running_median_filter_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for running_median_filter_top: streams samples with random idling
// and checks every median against a sliding-window predictor. Depends on rmf_pkg and the top.
module running_median_filter_top_tb;

	class median_scoreboard;
		logic [rmf_pkg::SAMPLE_W-1:0] store [rmf_pkg::MAX_WINDOW];
		int held;
		int oldest;
		logic [rmf_pkg::REQ_W-1:0] request;
		logic [rmf_pkg::SAMPLE_W-1:0] expected_medians [$];
		int mismatches;
		int checked;

		function new();
			held = 0;
			oldest = 0;
			request = rmf_pkg::REQ_RESET;
			mismatches = 0;
			checked = 0;
		endfunction

		function void set_request(input logic [rmf_pkg::REQ_W-1:0] value);
			request = value;
		endfunction

		function int window_length();
			int w;
			w = int'(request | rmf_pkg::REQ_W'(1));
			if (w < rmf_pkg::MIN_WINDOW) w = rmf_pkg::MIN_WINDOW;
			if (w > rmf_pkg::WIN_CAP) w = rmf_pkg::WIN_CAP;
			return w;
		endfunction

		function void note_reading(input logic [rmf_pkg::SAMPLE_W-1:0] value);
			logic [rmf_pkg::SAMPLE_W-1:0] ordered [rmf_pkg::MAX_WINDOW];
			logic [rmf_pkg::SAMPLE_W-1:0] v;
			int w;
			int i;
			int j;
			w = window_length();
			// A shrunk window drops all surplus samples before the new one goes in.
			while (held + 1 > w && held > 0) begin
				oldest = (oldest + 1) % rmf_pkg::MAX_WINDOW;
				held--;
			end
			store[(oldest + held) % rmf_pkg::MAX_WINDOW] = value;
			held++;
			for (i = 0; i < held; i++) begin
				v = store[(oldest + i) % rmf_pkg::MAX_WINDOW];
				j = i;
				while (j > 0 && ordered[j - 1] > v) begin
					ordered[j] = ordered[j - 1];
					j--;
				end
				ordered[j] = v;
			end
			expected_medians.insert(expected_medians.size(), ordered[held / 2]);
		endfunction

		function void check_median(input logic [rmf_pkg::SAMPLE_W-1:0] got);
			logic [rmf_pkg::SAMPLE_W-1:0] want;
			if (expected_medians.size() == 0) begin
				$display("%0t: unexpected median, expected none, actual %04h", $time, got);
				mismatches++;
				return;
			end
			want = expected_medians[0];
			expected_medians.delete(0);
			checked++;
			if (got !== want) begin
				$display("%0t: median mismatch, expected %04h, actual %04h", $time, want, got);
				mismatches++;
			end
		endfunction
	endclass

	localparam logic [rmf_pkg::REQ_W-1:0] WINDOW_SWEEP [13] = '{
		6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd14, 6'd15, 6'd16, 6'd17, 6'd62, 6'd63, 6'd7
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [15:0] sample
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;  // [15:0] median
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [5:0] cfg_data = '0;

	median_scoreboard sb;
	int sent = 0;
	int window_writes = 0;
	int send_gap_rate = 0;
	int stall_rate = 0;
	int stall_left = 0;

	running_median_filter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_rate != 0 && $urandom_range(0, stall_rate) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 6);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_median(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready) sb.note_reading(s_axis_tdata);
			if (cfg_valid && cfg_ready) sb.set_request(cfg_data);
		end
	end

	task automatic send_reading(input logic [15:0] value);
		if (send_gap_rate != 0 && $urandom_range(0, send_gap_rate) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	task automatic wait_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_medians.size() != 0) @(posedge clk);
	endtask

	task automatic write_window(input logic [5:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		window_writes++;
	endtask

	function automatic logic [15:0] pick_reading();
		case ($urandom_range(0, 9))
			0: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
			1, 2: return 16'($urandom_range(0, 7));
			3: return 16'($urandom_range(16'h7FF0, 16'h800F));
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic int pick_rate();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 2;
			default: return 8;
		endcase
	endfunction

	initial begin
		int phase;
		int n;
		int k;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The window fills under the reset length of five, then starts evicting.
		send_reading(16'h0000);
		send_reading(16'hFFFF);
		send_reading(16'h8000);
		send_reading(16'h0001);
		send_reading(16'h7FFF);
		send_reading(16'hFFFE);
		send_reading(16'hAAAA);
		send_reading(16'h5555);
		wait_results();
		// An oversized request saturates at the largest odd length.
		write_window(6'd63);
		for (k = 0; k < 10; k++) send_reading(16'(k * 7919));
		wait_results();
		// Shrinking to three drops most of the full window on the next sample.
		write_window(6'd0);
		send_reading(16'hFFFF);
		send_reading(16'h0000);
		send_reading(16'h3039);
		wait_results();

		phase = 0;
		while (sent < 1850) begin
			write_window(phase < 13 ? WINDOW_SWEEP[phase] : 6'($urandom_range(0, 63)));
			send_gap_rate = pick_rate();
			stall_rate = pick_rate();
			n = $urandom_range(40, 160);
			for (k = 0; k < n; k++) begin
				send_reading(pick_reading());
				if ($urandom_range(0, 99) == 0) wait_results();
			end
			wait_results();
			phase++;
		end

		write_window(6'($urandom_range(0, 63)));
		send_gap_rate = 0;
		stall_rate = 0;
		for (k = 0; k < 150; k++) send_reading(pick_reading());
		wait_results();
		repeat (300) @(posedge clk);

		$display("Sent %0d samples under %0d window settings, from three up to saturation.",
			sent, window_writes);
		$display("Compared %0d medians, %0d mismatches.", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_medians.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#30ms;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
design/rmf_pkg.sv
design/running_median_filter_top.sv
design/rmf_checker.sv
tb/running_median_filter_top_tb.sv
